// ----- rtl/sdx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdx_pkg
// Shared types, constants and the letter code table of the soundex encoder.
// ----------------------------------------------------------------------------
package sdx_pkg;

  localparam int CHAR_W   = 8;
  localparam int LETTER_W = 7;
  localparam int CODE_W   = 3;
  localparam int KEPT_W   = 2;
  localparam int NUM_KEPT = 3;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0]   ASCII_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0]   ASCII_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0]   ASCII_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0]   ASCII_LOW_Z = 8'h7A;
  localparam logic [CHAR_W-1:0]   CASE_OFFSET = 8'h20;
  localparam logic [CODE_W-1:0]   CODE_NONE   = 3'd7;
  localparam logic [CODE_W-1:0]   CODE_ZERO   = 3'd0;
  localparam logic [KEPT_W-1:0]   KEPT_FULL   = 2'(NUM_KEPT);

  // classified byte between front and back
  typedef struct packed {
    logic                is_letter;
    logic [LETTER_W-1:0] up;
    logic [CODE_W-1:0]   code;
    logic                last;
  } sdx_class_t;

  // result payload held in the output register
  typedef struct packed {
    logic                is_empty;
    logic [LETTER_W-1:0] lead_letter;
    logic [CODE_W-1:0]   digit_one;
    logic [CODE_W-1:0]   digit_two;
    logic [CODE_W-1:0]   digit_three;
  } sdx_result_t;

  // soundex class of an upper-case letter, index 0 is A
  function automatic logic [CODE_W-1:0] letter_code(input logic [4:0] idx);
    logic [CODE_W-1:0] c;
    begin
      unique case (idx)
        5'd1, 5'd5, 5'd15, 5'd21:                            c = 3'd1;
        5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: c = 3'd2;
        5'd3, 5'd19:                                         c = 3'd3;
        5'd11:                                               c = 3'd4;
        5'd12, 5'd13:                                        c = 3'd5;
        5'd17:                                               c = 3'd6;
        default:                                             c = CODE_ZERO;
      endcase
      return c;
    end
  endfunction

endpackage

// ----- rtl/sdx_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdx_in_if
// Input byte channel of the soundex encoder.
// ----------------------------------------------------------------------------
interface sdx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink (input valid, input char_in, input last_char, output ready);
endinterface

// ----- rtl/sdx_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdx_out_if
// Result channel of the soundex encoder.
// ----------------------------------------------------------------------------
interface sdx_out_if;
  logic       valid;
  logic       ready;
  logic       is_empty;
  logic [6:0] lead_letter;
  logic [2:0] digit_one;
  logic [2:0] digit_two;
  logic [2:0] digit_three;

  modport source (output valid, output is_empty, output lead_letter, output digit_one,
                  output digit_two, output digit_three, input ready);
  modport sink (input valid, input is_empty, input lead_letter, input digit_one,
                input digit_two, input digit_three, output ready);
endinterface

// ----- rtl/sdx_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdx_front
// Accepts bytes, folds case and looks up the letter class.
// ----------------------------------------------------------------------------
module sdx_front
  import sdx_pkg::*;
(
  sdx_in_if.sink     in_ch,
  input  logic       q_ready,
  output logic       q_valid,
  output sdx_class_t q_item
);

  logic [CHAR_W-1:0] ch;
  logic              is_low;
  logic              is_up;
  logic [CHAR_W-1:0] folded;
  logic [CHAR_W-1:0] idx;

  always_comb begin
    ch     = in_ch.char_in;
    is_low = (ch >= ASCII_LOW_A) && (ch <= ASCII_LOW_Z);
    is_up  = (ch >= ASCII_UP_A) && (ch <= ASCII_UP_Z);
    folded = is_low ? (ch - CASE_OFFSET) : ch;
    idx    = folded - ASCII_UP_A;

    q_item.is_letter = is_low || is_up;
    q_item.up        = (is_low || is_up) ? folded[LETTER_W-1:0] : '0;
    q_item.code      = letter_code(idx[4:0]);
    q_item.last      = in_ch.last_char;
  end

  assign q_valid     = in_ch.valid;
  assign in_ch.ready = q_ready;

endmodule

// ----- rtl/sdx_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdx_queue
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module sdx_queue
  import sdx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  sdx_class_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output sdx_class_t pop_item
);

  sdx_class_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop;

  assign push_ready = (count_r < QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/sdx_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdx_back
// Keeps the running code state and loads the result register on the last byte.
// ----------------------------------------------------------------------------
module sdx_back
  import sdx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  sdx_class_t q_item,
  sdx_out_if.source  out_ch
);

  logic                have_letter_r, have_letter_nxt;
  logic [LETTER_W-1:0] first_letter_r, first_letter_nxt;
  logic [CODE_W-1:0]   prior_code_r, prior_code_nxt;
  logic [KEPT_W-1:0]   digits_kept_r, digits_kept_nxt;
  logic [CODE_W-1:0]   kept_r [NUM_KEPT];
  logic [CODE_W-1:0]   kept_nxt [NUM_KEPT];
  logic                out_valid_r, out_valid_nxt;
  sdx_result_t         result_r, result_nxt;
  logic                out_free;
  logic                pop;
  logic                emit;

  assign out_free = !out_valid_r || out_ch.ready;
  assign q_ready  = !q_item.last || out_free;
  assign pop      = q_valid && q_ready;
  assign emit     = pop && q_item.last;

  always_comb begin
    have_letter_nxt  = have_letter_r;
    first_letter_nxt = first_letter_r;
    prior_code_nxt   = prior_code_r;
    digits_kept_nxt  = digits_kept_r;
    kept_nxt         = kept_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    result_nxt       = result_r;

    if (pop && q_item.is_letter) begin
      if (!have_letter_r) begin
        have_letter_nxt  = 1'b1;
        first_letter_nxt = q_item.up;
      end else if (q_item.code != prior_code_r) begin
        prior_code_nxt = q_item.code;
        if (q_item.code != CODE_ZERO && digits_kept_r < KEPT_FULL) begin
          for (int i = 0; i < NUM_KEPT; i++) begin
            if (digits_kept_r == KEPT_W'(i)) begin
              kept_nxt[i] = q_item.code;
            end
          end
          digits_kept_nxt = digits_kept_r + 1'b1;
        end
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      if (!have_letter_nxt) begin
        result_nxt = '0;
        result_nxt.is_empty = 1'b1;
      end else begin
        result_nxt.is_empty    = 1'b0;
        result_nxt.lead_letter = first_letter_nxt;
        result_nxt.digit_one   = kept_nxt[0];
        result_nxt.digit_two   = kept_nxt[1];
        result_nxt.digit_three = kept_nxt[2];
      end
      have_letter_nxt  = 1'b0;
      first_letter_nxt = '0;
      prior_code_nxt   = CODE_NONE;
      digits_kept_nxt  = '0;
      for (int i = 0; i < NUM_KEPT; i++) begin
        kept_nxt[i] = CODE_ZERO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_letter_r  <= 1'b0;
      first_letter_r <= '0;
      prior_code_r   <= CODE_NONE;
      digits_kept_r  <= '0;
      for (int i = 0; i < NUM_KEPT; i++) begin
        kept_r[i] <= CODE_ZERO;
      end
      out_valid_r    <= 1'b0;
    end else begin
      have_letter_r  <= have_letter_nxt;
      first_letter_r <= first_letter_nxt;
      prior_code_r   <= prior_code_nxt;
      digits_kept_r  <= digits_kept_nxt;
      kept_r         <= kept_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.is_empty    = result_r.is_empty;
  assign out_ch.lead_letter = result_r.lead_letter;
  assign out_ch.digit_one   = result_r.digit_one;
  assign out_ch.digit_two   = result_r.digit_two;
  assign out_ch.digit_three = result_r.digit_three;

endmodule

// ----- rtl/soundex_encoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soundex_encoder_core
// Streaming soundex encoder, one string byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the queue has room, and gives one
// result per string on the byte marked last: the first letter and three class
// digits, or is_empty when the string held no letters. A byte is classified
// on entry and written to a two-entry queue; the back end drains one entry per
// cycle, so the sustained rate is one byte per clock, unless a result waits on
// a stalled output. A result waits in the output register; a stalled output
// holds only a last byte, and the queue keeps taking input until it is full.
module soundex_encoder_core
  import sdx_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  sdx_in_if.sink    in_ch,
  sdx_out_if.source out_ch
);

  logic       front_valid;
  logic       front_ready;
  sdx_class_t front_item;
  logic       back_valid;
  logic       back_ready;
  sdx_class_t back_item;

  sdx_front u_front (
    .in_ch   (in_ch),
    .q_ready (front_ready),
    .q_valid (front_valid),
    .q_item  (front_item)
  );

  sdx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item)
  );

  sdx_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (back_valid),
    .q_ready (back_ready),
    .q_item  (back_item),
    .out_ch  (out_ch)
  );

endmodule
